/* hdl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and types of the chunked byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int MAX_CHUNK   = 8;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CAP_W  = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W  = 4;
    localparam int DATA_W = 64;
    localparam int IDX_W  = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int STS_W  = 2;
    localparam int BYTE_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PUSH,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic latch_status;
        logic push_step;
        logic pop_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic item_ok;
        logic is_pop;
        logic last_byte;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/brb_ram.sv */
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/brb_ctrl.sv */
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: checks a request, steps its bytes, hands the result over.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ctrl
    import brb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.item_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.is_pop) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.last_byte) begin
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                if (i_sts.last_byte) begin
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready            = 1'b0;
        o_cmd              = '0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_CHECK: begin
                o_cmd.latch_status = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push_step = 1'b1;
            end
            S_POP: begin
                o_cmd.pop_step = 1'b1;
            end
            S_POP_WAIT: begin
                o_cmd = '0;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/brb_dp.sv */
// ----------------------------------------------------------------------------
// brb_dp
// Datapath: capacity, pointers, fill count, byte store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_dp
    import brb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_req_type,
    input  wire logic [CNT_W-1:0]  i_byte_count,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]  i_cfg_wr_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [STS_W-1:0]  o_status,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [CAP_W-1:0]  o_fill_level
);

    logic [CAP_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [CAP_W-1:0]  r_held;
    logic              r_pop;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_dout;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_pend;
    logic [IDX_W-1:0]  r_rd_slot;
    logic [STS_W-1:0]  r_status;
    logic              r_out_valid;
    logic [STS_W-1:0]  r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic [CAP_W-1:0]  r_out_fill;

    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W:0]    held_sum;
    logic [STS_W-1:0]  status_now;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_free;

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [CAP_W-1:0]  cap);
        logic [CAP_W-1:0] nxt;
        nxt = {1'b0, p} + CAP_W'(1);
        return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
    endfunction

    // capacity above the store size saturates
    assign cap_eff  = (r_cap > CAP_W'(STORE_DEPTH)) ? CAP_W'(STORE_DEPTH) : r_cap;
    assign held_sum = {1'b0, r_held} + (CAP_W+1)'(r_count);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        if (r_count == '0 || r_count > CNT_W'(MAX_CHUNK)
                || CAP_W'(r_count) > cap_eff) begin
            status_now = ST_INVALID;
        end else if (!r_pop) begin
            status_now = (held_sum > {1'b0, cap_eff}) ? ST_FULL : ST_OK;
        end else begin
            status_now = (r_held < CAP_W'(r_count)) ? ST_EMPTY : ST_OK;
        end
    end

    assign o_sts.item_ok   = (status_now == ST_OK);
    assign o_sts.is_pop    = r_pop;
    assign o_sts.last_byte = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_sts.out_free  = out_free;

    brb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push_step),
        .i_waddr(r_wr_ptr),
        .i_wdata(r_data[BYTE_W-1:0]),
        .i_re   (i_cmd.pop_step),
        .i_raddr(r_rd_ptr),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_held      <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.pop_step;
            if (i_cfg_wr_en) begin
                r_cap    <= i_cfg_wr_data;
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_held   <= '0;
            end else begin
                if (i_cmd.push_step) begin
                    r_wr_ptr <= advance(r_wr_ptr, cap_eff);
                    if (o_sts.last_byte) begin
                        r_held <= held_sum[CAP_W-1:0];
                    end
                end
                if (i_cmd.pop_step) begin
                    r_rd_ptr <= advance(r_rd_ptr, cap_eff);
                    if (o_sts.last_byte) begin
                        r_held <= r_held - CAP_W'(r_count);
                    end
                end
            end
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.push_step || i_cmd.pop_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pop   <= i_req_type;
            r_count <= i_byte_count;
            r_data  <= i_data_in;
        end else if (i_cmd.push_step) begin
            r_data <= r_data >> BYTE_W;
        end
        if (i_cmd.accept) begin
            r_dout <= '0;
        end else if (r_rd_pend) begin
            r_dout[{r_rd_slot, 3'b000} +: BYTE_W] <= ram_rdata;
        end
        if (i_cmd.pop_step) begin
            r_rd_slot <= r_idx;
        end
        if (i_cmd.latch_status) begin
            r_status <= status_now;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_data   <= r_dout;
            r_out_fill   <= r_held;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_data_out   = r_out_data;
    assign o_fill_level = r_out_fill;

`ifndef SYNTHESIS
    a_held_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= cap_eff)
        else $error("fill count above capacity");
    a_wr_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cap_eff == '0) || (CAP_W'(r_wr_ptr) < cap_eff))
        else $error("write pointer out of range");
    a_rd_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cap_eff == '0) || (CAP_W'(r_rd_ptr) < cap_eff))
        else $error("read pointer out of range");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

/* hdl/byte_ring_buffer_chunked_top.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked_top
// Byte FIFO on a circular store, pushed and popped in chunks of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one request: push or pop, a byte
// count and up to eight push bytes, first byte in bits 7:0. Output channel
// (o_valid/i_ready) returns one result per request: status, popped bytes and
// the fill level after the request.
// Bytes move one per cycle through the byte-wide store (one write port, one
// read port); a pop adds a wait state for the registered read data and a
// rejected request skips the byte steps. The next request is taken right
// after its predecessor's result is loaded into the output register, which
// holds the result while the receiver stalls; a second result waits inside
// until the first is taken.
// Reset (synchronous, active low) empties the queue and sets the capacity to
// 256. A write on the capacity port also empties the queue; it must only be
// issued while no request is in flight. No clearing pass is needed after
// reset.
`default_nettype none

module byte_ring_buffer_chunked_top
    import brb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_req_type,
    input  wire logic [CNT_W-1:0]  i_byte_count,
    input  wire logic [DATA_W-1:0] i_data_in,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [STS_W-1:0]  o_status,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [CAP_W-1:0]  o_fill_level,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]  i_cfg_wr_data
);

    t_cmd    cmd;
    t_dp_sts dp_sts;

    brb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (dp_sts),
        .o_cmd  (cmd)
    );

    brb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (dp_sts),
        .i_req_type   (i_req_type),
        .i_byte_count (i_byte_count),
        .i_data_in    (i_data_in),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_fill_level (o_fill_level)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chunked byte ring buffer.
// ----------------------------------------------------------------------------
// The bench sends push and pop requests over a valid/ready channel. It keeps
// its own model of the ring buffer and works out the status, the popped bytes
// and the fill level of every accepted request. Each returned result is
// checked in order against that model. Directed cases come first: empty and
// full, invalid counts, wrap-around and extreme capacities. Random traffic
// follows under several idle and stall patterns, with one long receiver
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench
    import brb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [DATA_W-1:0] data;
        logic [CAP_W-1:0]  fill;
    } t_ring_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_req_type;
    logic [CNT_W-1:0]  i_byte_count;
    logic [DATA_W-1:0] i_data_in;
    logic              o_valid;
    logic              i_ready;
    logic [STS_W-1:0]  o_status;
    logic [DATA_W-1:0] o_data_out;
    logic [CAP_W-1:0]  o_fill_level;
    logic              i_cfg_wr_en;
    logic [CAP_W-1:0]  i_cfg_wr_data;

    // Ring buffer model
    logic [BYTE_W-1:0] model_store [STORE_DEPTH];
    int                model_rd_ptr;
    int                model_wr_ptr;
    int                model_held;
    logic [CAP_W-1:0]  model_capacity;
    logic [STS_W-1:0]  last_status;

    t_ring_result expected_results[$];
    t_ring_result oldest_result;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_left;
    int  mismatches;
    int  cycle_count;

    byte_ring_buffer_chunked_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_byte_count  (i_byte_count),
        .i_data_in     (i_data_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_fill_level  (o_fill_level),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int effective_capacity();
        return (int'(model_capacity) > STORE_DEPTH) ? STORE_DEPTH : int'(model_capacity);
    endfunction

    // Applies one accepted request to the model and queues its result
    function automatic void predict_request(input logic req, input logic [CNT_W-1:0] cnt,
                                            input logic [DATA_W-1:0] din);
        t_ring_result res;
        int           cap;
        int           n;
        cap = effective_capacity();
        n   = int'(cnt);
        res = '0;
        res.status = ST_OK;
        if (n == 0 || n > MAX_CHUNK || n > cap) begin
            res.status = ST_INVALID;
        end else if (req == REQ_PUSH) begin
            if (model_held + n > cap) begin
                res.status = ST_FULL;
            end else begin
                for (int i = 0; i < n; i++) begin
                    model_store[model_wr_ptr] = din[BYTE_W*i +: BYTE_W];
                    model_wr_ptr = (model_wr_ptr + 1 >= cap) ? 0 : model_wr_ptr + 1;
                end
                model_held += n;
            end
        end else begin
            if (model_held < n) begin
                res.status = ST_EMPTY;
            end else begin
                for (int i = 0; i < n; i++) begin
                    res.data[BYTE_W*i +: BYTE_W] = model_store[model_rd_ptr];
                    model_rd_ptr = (model_rd_ptr + 1 >= cap) ? 0 : model_rd_ptr + 1;
                end
                model_held -= n;
            end
        end
        res.fill    = CAP_W'(model_held);
        last_status = res.status;
        expected_results.push_back(res);
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d", o_status);
                mismatches++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                    mismatches++;
                end
                if (o_data_out !== oldest_result.data) begin
                    $error("data_out: expected %h, got %h", oldest_result.data, o_data_out);
                    mismatches++;
                end
                if (o_fill_level !== oldest_result.fill) begin
                    $error("fill_level: expected %0d, got %0d", oldest_result.fill,
                           o_fill_level);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_req(input logic req, input logic [CNT_W-1:0] cnt,
                            input logic [DATA_W-1:0] din);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_byte_count <= cnt;
        i_data_in    <= din;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(req, cnt, din);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_capacity = value;
        model_rd_ptr   = 0;
        model_wr_ptr   = 0;
        model_held     = 0;
    endtask

    task automatic test_reset_state();
        send_req(REQ_POP,  4'd1,  '0);
        send_req(REQ_PUSH, 4'd0,  64'h1122_3344_5566_7788);
        send_req(REQ_PUSH, 4'd15, '1);
        send_req(REQ_POP,  4'd9,  '0);
        send_req(REQ_PUSH, 4'd8,  '1);
        send_req(REQ_PUSH, 4'd8,  '0);
        send_req(REQ_PUSH, 4'd1,  64'hFFFF_FFFF_FFFF_FFA5);
        send_req(REQ_POP,  4'd8,  '1);
        send_req(REQ_POP,  4'd8,  '0);
        send_req(REQ_POP,  4'd1,  '0);
        send_req(REQ_POP,  4'd1,  '0);
    endtask

    task automatic test_wrap_small_capacity();
        write_capacity(CAP_W'(5));
        send_req(REQ_PUSH, 4'd4, 64'h0000_0000_0403_0201);
        send_req(REQ_PUSH, 4'd2, 64'h0000_0000_0000_0706);
        send_req(REQ_PUSH, 4'd1, 64'h0000_0000_0000_0005);
        send_req(REQ_PUSH, 4'd1, 64'h0000_0000_0000_0009);
        send_req(REQ_POP,  4'd3, '0);
        // write pointer has already wrapped to the start of the store
        send_req(REQ_PUSH, 4'd3, 64'h0000_0000_00CC_BBAA);
        send_req(REQ_POP,  4'd5, '0);
        send_req(REQ_PUSH, 4'd6, '1);
        send_req(REQ_POP,  4'd1, '0);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(CAP_W'(0));
        send_req(REQ_PUSH, 4'd1, 64'h0000_0000_0000_0042);
        send_req(REQ_POP,  4'd1, '0);
        write_capacity(CAP_W'(1));
        send_req(REQ_PUSH, 4'd1, 64'h0000_0000_0000_005A);
        send_req(REQ_PUSH, 4'd1, 64'h0000_0000_0000_00C3);
        send_req(REQ_POP,  4'd1, '0);
        send_req(REQ_POP,  4'd2, '0);
        // above the store depth: acts as a full-depth store
        write_capacity(CAP_W'(511));
        send_req(REQ_PUSH, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_req(REQ_POP,  4'd8, '0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct, input logic [CAP_W-1:0] cap);
        logic             filling;
        logic             req;
        logic [CNT_W-1:0] cnt;
        int               max_cnt;
        write_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        filling        = 1'b1;
        repeat (n_items) begin
            max_cnt = (effective_capacity() < MAX_CHUNK) ? effective_capacity() : MAX_CHUNK;
            if ($urandom_range(99) < 85 && max_cnt > 0)
                cnt = CNT_W'($urandom_range(max_cnt, 1));
            else
                cnt = CNT_W'($urandom_range(15, 0));
            // drift between filling and draining so full and empty both occur
            req = ($urandom_range(99) < 75) ? ~filling : filling;
            send_req(req, cnt, {$urandom, $urandom});
            if (last_status == ST_FULL || last_status == ST_EMPTY || $urandom_range(15) == 0)
                filling = ~filling;
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_capacity(CAP_W'(64));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_left = 400;
        repeat (25) send_req(REQ_PUSH, CNT_W'($urandom_range(MAX_CHUNK, 1)), {$urandom, $urandom});
        repeat (15) send_req(REQ_POP, CNT_W'($urandom_range(MAX_CHUNK, 1)), {$urandom, $urandom});
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req_type     = REQ_PUSH;
        i_byte_count   = '0;
        i_data_in      = '0;
        i_ready        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        mismatches     = 0;
        cycle_count    = 0;
        model_rd_ptr   = 0;
        model_wr_ptr   = 0;
        model_held     = 0;
        model_capacity = CAP_RESET;
        last_status    = ST_OK;
        foreach (model_store[i]) model_store[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_wrap_small_capacity();
        test_capacity_extremes();
        test_random_traffic(100, 0,  0,  CAP_W'(256));
        test_random_traffic(100, 66, 0,  CAP_W'(13));
        test_random_traffic(100, 0,  66, CAP_W'(8));
        test_random_traffic(100, 14, 14, CAP_W'(300));
        test_random_traffic(50,  14, 14, CAP_W'(2));
        test_output_backpressure();
        wait_drained();

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
